@@ rtl/core/adpr_pkg.sv @@
// adpr_pkg: shared types and default constants for the antialiased disc renderer.
// No dependencies; imported by every module of the block.
package adpr_pkg;

    // Default sizes, handed to the top level parameters
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int LEVEL_BITS_DEF = 16;

    // Reset values of the frame size registers, in whole pixels
    localparam int FRAME_COLS_RST = 640;
    localparam int FRAME_ROWS_RST = 480;

    typedef enum logic [1:0] {
        REG_INTERIOR = 2'd0,
        REG_RING     = 2'd1,
        REG_EXTERIOR = 2'd2
    } t_region;

    // Per-stage control that travels with the data
    typedef struct packed {
        logic    valid;
        t_region region;
    } t_tag;

endpackage

@@ rtl/core/adpr_dist.sv @@
// adpr_dist: pixel offset, squared distance and region classification stages.
// Depends on adpr_pkg.
module adpr_dist import adpr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int FIX = COORD_BITS + FRAC_BITS,
    localparam int D2W = 2 * FIX + 3,
    localparam int SQW = 2 * FIX + 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_pixel_col,
    input  logic [COORD_BITS-1:0] i_pixel_row,
    input  logic [FIX-1:0]        i_center_col,
    input  logic [FIX-1:0]        i_center_row,
    input  logic [FIX-1:0]        i_radius,
    input  logic [FIX-1:0]        i_width,
    output t_tag                  o_tag,
    output logic [D2W-1:0]        o_d2x4
);

    // ring bounds, refreshed every cycle from the config registers
    logic [FIX+1:0]   r_outer_edge;
    logic [FIX:0]     r_inner_edge;
    logic             r_inner_ok;
    logic [SQW-1:0]   r_outer_sq;
    logic [2*FIX+1:0] r_inner_sq;

    logic                  r_v0, r_v1, r_v2;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [FIX-1:0]        r_dx, r_dy;
    logic [2*FIX-1:0]      r_sqx, r_sqy;
    t_tag                  r_tag;
    logic [D2W-1:0]        r_d2x4;

    logic [FIX-1:0]   px_fix, py_fix;
    logic [2*FIX:0]   n_sum;
    logic [D2W-1:0]   n_d2x4;
    t_region          n_region;

    always_ff @(posedge i_clk) begin
        r_outer_edge <= {1'b0, i_radius, 1'b0} + (FIX+2)'(i_width);
        r_inner_edge <= {i_radius, 1'b0} - {1'b0, i_width};
        r_inner_ok   <= {i_radius, 1'b0} > {1'b0, i_width};
        r_outer_sq   <= r_outer_edge * r_outer_edge;
        r_inner_sq   <= r_inner_edge * r_inner_edge;
    end

    assign px_fix = FIX'(r_px) << FRAC_BITS;
    assign py_fix = FIX'(r_py) << FRAC_BITS;

    always_comb begin
        n_sum  = {1'b0, r_sqx} + {1'b0, r_sqy};
        n_d2x4 = {n_sum, 2'b00};
        if ({1'b0, n_d2x4} > r_outer_sq) begin
            n_region = REG_EXTERIOR;
        end else if (r_inner_ok && (n_d2x4 < {1'b0, r_inner_sq})) begin
            n_region = REG_INTERIOR;
        end else begin
            n_region = REG_RING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_tag <= '0;
        end else if (i_en) begin
            r_v0  <= i_valid;
            r_v1  <= r_v0;
            r_v2  <= r_v1;
            r_tag <= '{valid: r_v2, region: n_region};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= i_pixel_col;
            r_py   <= i_pixel_row;
            r_dx   <= (px_fix >= i_center_col) ? px_fix - i_center_col : i_center_col - px_fix;
            r_dy   <= (py_fix >= i_center_row) ? py_fix - i_center_row : i_center_row - py_fix;
            r_sqx  <= r_dx * r_dx;
            r_sqy  <= r_dy * r_dy;
            r_d2x4 <= n_d2x4;
        end
    end

    assign o_tag  = r_tag;
    assign o_d2x4 = r_d2x4;

endmodule

@@ rtl/core/adpr_sqrt.sv @@
// adpr_sqrt: pipelined integer square root, one root bit per stage.
// Depends on adpr_pkg.
module adpr_sqrt import adpr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int FIX = COORD_BITS + FRAC_BITS,
    localparam int D2W = 2 * FIX + 3,
    localparam int QB  = FIX + 2,
    localparam int RW  = 2 * QB,
    localparam int RB  = QB + 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  t_tag           i_tag,
    input  logic [D2W-1:0] i_d2x4,
    output t_tag           o_tag,
    output logic [QB-1:0]  o_root
);

    logic [RB-1:0] r_rem  [QB];
    logic [QB-1:0] r_root [QB];
    logic [RW-1:0] r_rad  [QB];
    t_tag          r_tag  [QB];

    logic [RB-1:0] n_rem  [QB];
    logic [QB-1:0] n_root [QB];
    logic [RW-1:0] n_rad  [QB];
    t_tag          n_tag  [QB];

    always_comb begin
        logic [RB-1:0] rem_in;
        logic [QB-1:0] root_in;
        logic [RW-1:0] rad_in;
        t_tag          tag_in;
        logic [RB+1:0] rem_sh;
        logic [RB+1:0] trial;
        for (int k = 0; k < QB; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = RW'(i_d2x4);
                tag_in  = i_tag;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                rad_in  = r_rad[k-1];
                tag_in  = r_tag[k-1];
            end
            rem_sh = {rem_in, rad_in[RW-1 -: 2]};
            trial  = {RB'(root_in), 2'b01};
            if (rem_sh >= trial) begin
                n_rem[k]  = RB'(rem_sh - trial);
                n_root[k] = {root_in[QB-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem_sh[RB-1:0];
                n_root[k] = {root_in[QB-2:0], 1'b0};
            end
            n_rad[k] = rad_in << 2;
            n_tag[k] = tag_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) begin
                r_tag[k] <= '0;
            end
        end else if (i_en) begin
            for (int k = 0; k < QB; k++) begin
                r_tag[k] <= n_tag[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QB; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
            end
        end
    end

    assign o_tag  = r_tag[QB-1];
    assign o_root = r_root[QB-1];

endmodule

@@ rtl/core/adpr_blend.sv @@
// adpr_blend: ring position, weight products and blend numerator stages.
// Depends on adpr_pkg.
module adpr_blend import adpr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF,
    localparam int FIX = COORD_BITS + FRAC_BITS,
    localparam int QB  = FIX + 2,
    localparam int TW  = FIX + 1,
    localparam int NB  = FIX + LEVEL_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_tag                  i_tag,
    input  logic [QB-1:0]         i_root,
    input  logic [FIX-1:0]        i_radius,
    input  logic [FIX-1:0]        i_width,
    input  logic [LEVEL_BITS-1:0] i_inner,
    input  logic [LEVEL_BITS-1:0] i_outer,
    output t_tag                  o_tag,
    output logic [NB-1:0]         o_num
);

    t_tag                    r_tag0, r_tag1, r_tag2;
    logic [TW-1:0]           r_t;
    logic [TW+LEVEL_BITS-1:0] r_pa, r_pb;
    logic [NB-1:0]           r_num;

    logic [TW-1:0]          span;
    logic signed [FIX+3:0]  diff;
    logic [TW-1:0]          n_t;

    assign span = {i_width, 1'b0};

    // t = 2d - (2r - s), clamped to the ring span
    always_comb begin
        diff = $signed({2'b00, i_root}) + $signed({4'b0000, i_width})
             - $signed({3'b000, i_radius, 1'b0});
        if (diff < 0) begin
            n_t = '0;
        end else if (diff > $signed({3'b000, span})) begin
            n_t = span;
        end else begin
            n_t = diff[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0 <= '0;
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else if (i_en) begin
            r_tag0 <= i_tag;
            r_tag1 <= r_tag0;
            r_tag2 <= r_tag1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t   <= n_t;
            r_pa  <= (span - r_t) * i_inner;
            r_pb  <= r_t * i_outer;
            r_num <= NB'(r_pa) + NB'(r_pb) + NB'(i_width);
        end
    end

    assign o_tag = r_tag2;
    assign o_num = r_num;

endmodule

@@ rtl/core/adpr_div.sv @@
// adpr_div: pipelined restoring divider, one quotient bit per stage.
// Depends on adpr_pkg.
module adpr_div import adpr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF,
    localparam int FIX = COORD_BITS + FRAC_BITS,
    localparam int TW  = FIX + 1,
    localparam int NB  = FIX + LEVEL_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_tag                  i_tag,
    input  logic [NB-1:0]         i_num,
    input  logic [FIX-1:0]        i_width,
    output t_tag                  o_tag,
    output logic [LEVEL_BITS-1:0] o_quot
);

    logic [NB-1:0]         r_rem  [LEVEL_BITS];
    logic [LEVEL_BITS-1:0] r_quot [LEVEL_BITS];
    t_tag                  r_tag  [LEVEL_BITS];

    logic [NB-1:0]         n_rem  [LEVEL_BITS];
    logic [LEVEL_BITS-1:0] n_quot [LEVEL_BITS];
    t_tag                  n_tag  [LEVEL_BITS];

    logic [TW-1:0] span;
    assign span = {i_width, 1'b0};

    // numerator < span << LEVEL_BITS, so the quotient fits LEVEL_BITS bits
    always_comb begin
        logic [NB-1:0]         rem_in;
        logic [LEVEL_BITS-1:0] quot_in;
        t_tag                  tag_in;
        logic [NB-1:0]         dvs;
        for (int k = 0; k < LEVEL_BITS; k++) begin
            if (k == 0) begin
                rem_in  = i_num;
                quot_in = '0;
                tag_in  = i_tag;
            end else begin
                rem_in  = r_rem[k-1];
                quot_in = r_quot[k-1];
                tag_in  = r_tag[k-1];
            end
            dvs = NB'(span) << (LEVEL_BITS - 1 - k);
            if (rem_in >= dvs) begin
                n_rem[k]  = rem_in - dvs;
                n_quot[k] = {quot_in[LEVEL_BITS-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem_in;
                n_quot[k] = {quot_in[LEVEL_BITS-2:0], 1'b0};
            end
            n_tag[k] = tag_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEVEL_BITS; k++) begin
                r_tag[k] <= '0;
            end
        end else if (i_en) begin
            for (int k = 0; k < LEVEL_BITS; k++) begin
                r_tag[k] <= n_tag[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LEVEL_BITS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_quot[k] <= n_quot[k];
            end
        end
    end

    assign o_tag  = r_tag[LEVEL_BITS-1];
    assign o_quot = r_quot[LEVEL_BITS-1];

endmodule

@@ rtl/core/antialiased_disc_pixel_render.sv @@
// antialiased_disc_pixel_render: top level, config registers, pipeline and output queue.
// Depends on adpr_pkg, adpr_dist, adpr_sqrt, adpr_blend, adpr_div.
//
// Renders one pixel of an antialiased disc per clock. Each request carries an integer
// pixel column and row; the result gives the pixel level (inner level, outer level or a
// linear blend across a ring of width edge_width centred on the radius, rounded to
// nearest), the region code and a flag telling whether the disc lies inside the frame
// (level forced to 0 when it does not). The pipeline takes a new request every cycle
// unless held as below, and the square root and divider work one result bit per
// stage. A two-entry output queue decouples the sides: input stays ready while a
// result waits, and the whole pipeline holds only when the queue is full and a
// finished result is ready to leave. Configuration goes through the APB-style port
// (registers at byte address 4*index) and must be written only while no request is
// in flight. There is no clearing pass after reset.
module antialiased_disc_pixel_render import adpr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF,
    localparam int ADDR_BITS = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // pixel requests
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_pixel_col,
    input  logic [COORD_BITS-1:0] i_pixel_row,
    // rendered pixels
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LEVEL_BITS-1:0] o_pixel_level,
    output logic [1:0]            o_region,
    output logic                  o_disc_fits
);

    localparam int FIX = COORD_BITS + FRAC_BITS;
    localparam int D2W = 2 * FIX + 3;
    localparam int QB  = FIX + 2;
    localparam int NB  = FIX + LEVEL_BITS + 2;
    localparam int FW  = COORD_BITS + 1;

    localparam logic [2:0] CFG_CENTER_COL  = 3'd0;
    localparam logic [2:0] CFG_CENTER_ROW  = 3'd1;
    localparam logic [2:0] CFG_DISC_RADIUS = 3'd2;
    localparam logic [2:0] CFG_EDGE_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_INNER_LEVEL = 3'd4;
    localparam logic [2:0] CFG_OUTER_LEVEL = 3'd5;
    localparam logic [2:0] CFG_FRAME_COLS  = 3'd6;
    localparam logic [2:0] CFG_FRAME_ROWS  = 3'd7;

    localparam logic [1:0] Q_FULL = 2'd2;

    // ---------------- configuration registers ----------------
    logic [FIX-1:0]        r_center_col, r_center_row, r_disc_radius, r_edge_width;
    logic [LEVEL_BITS-1:0] r_inner_level, r_outer_level;
    logic [FW-1:0]         r_frame_cols, r_frame_rows;
    logic                  r_fits;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col  <= '0;
            r_center_row  <= '0;
            r_disc_radius <= '0;
            r_edge_width  <= FIX'(1) << FRAC_BITS;
            r_inner_level <= '0;
            r_outer_level <= '1;
            r_frame_cols  <= FW'(FRAME_COLS_RST);
            r_frame_rows  <= FW'(FRAME_ROWS_RST);
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_CENTER_COL:  r_center_col  <= pwdata[FIX-1:0];
                CFG_CENTER_ROW:  r_center_row  <= pwdata[FIX-1:0];
                CFG_DISC_RADIUS: r_disc_radius <= pwdata[FIX-1:0];
                CFG_EDGE_WIDTH:  r_edge_width  <= pwdata[FIX-1:0];
                CFG_INNER_LEVEL: r_inner_level <= pwdata[LEVEL_BITS-1:0];
                CFG_OUTER_LEVEL: r_outer_level <= pwdata[LEVEL_BITS-1:0];
                CFG_FRAME_COLS:  r_frame_cols  <= pwdata[FW-1:0];
                CFG_FRAME_ROWS:  r_frame_rows  <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_CENTER_COL:  prdata = 32'(r_center_col);
            CFG_CENTER_ROW:  prdata = 32'(r_center_row);
            CFG_DISC_RADIUS: prdata = 32'(r_disc_radius);
            CFG_EDGE_WIDTH:  prdata = 32'(r_edge_width);
            CFG_INNER_LEVEL: prdata = 32'(r_inner_level);
            CFG_OUTER_LEVEL: prdata = 32'(r_outer_level);
            CFG_FRAME_COLS:  prdata = 32'(r_frame_cols);
            CFG_FRAME_ROWS:  prdata = 32'(r_frame_rows);
            default:         prdata = '0;
        endcase
    end

    // fit check, registered; config is stable long before a result needs it
    always_ff @(posedge i_clk) begin
        r_fits <= !((r_center_col < r_disc_radius) || (r_center_row < r_disc_radius)
                 || ((FIX+1)'(r_center_col) + (FIX+1)'(r_disc_radius)
                     > ((FIX+1)'(r_frame_cols) << FRAC_BITS))
                 || ((FIX+1)'(r_center_row) + (FIX+1)'(r_disc_radius)
                     > ((FIX+1)'(r_frame_rows) << FRAC_BITS)));
    end

    // ---------------- pipeline ----------------
    // Single advance enable: the pipe holds only when the queue is full and
    // the last stage has a result to push.
    logic en;

    t_tag                  dist_tag, sqrt_tag, blend_tag, div_tag;
    logic [D2W-1:0]        dist_d2x4;
    logic [QB-1:0]         sqrt_root;
    logic [NB-1:0]         blend_num;
    logic [LEVEL_BITS-1:0] div_quot;

    logic [1:0] r_cnt;

    assign en         = (r_cnt != Q_FULL) || !div_tag.valid;
    assign o_in_ready = en;

    adpr_dist #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in_valid),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_center_col (r_center_col),
        .i_center_row (r_center_row),
        .i_radius     (r_disc_radius),
        .i_width      (r_edge_width),
        .o_tag        (dist_tag),
        .o_d2x4       (dist_d2x4)
    );

    adpr_sqrt #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (dist_tag),
        .i_d2x4  (dist_d2x4),
        .o_tag   (sqrt_tag),
        .o_root  (sqrt_root)
    );

    adpr_blend #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_tag    (sqrt_tag),
        .i_root   (sqrt_root),
        .i_radius (r_disc_radius),
        .i_width  (r_edge_width),
        .i_inner  (r_inner_level),
        .i_outer  (r_outer_level),
        .o_tag    (blend_tag),
        .o_num    (blend_num)
    );

    adpr_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (blend_tag),
        .i_num   (blend_num),
        .i_width (r_edge_width),
        .o_tag   (div_tag),
        .o_quot  (div_quot)
    );

    // ---------------- final level select ----------------
    // Zero edge width: the ring holds only pixels exactly at the radius, inner level.
    logic [LEVEL_BITS-1:0] sel_level;
    logic [LEVEL_BITS-1:0] n_level;

    always_comb begin
        case (div_tag.region)
            REG_EXTERIOR: sel_level = r_outer_level;
            REG_INTERIOR: sel_level = r_inner_level;
            REG_RING:     sel_level = (r_edge_width == '0) ? r_inner_level : div_quot;
            default:      sel_level = r_inner_level;
        endcase
        n_level = r_fits ? sel_level : '0;
    end

    // ---------------- output queue, two entries ----------------
    logic [LEVEL_BITS-1:0] r_q_level  [2];
    t_region               r_q_region [2];
    logic                  r_q_fits   [2];
    logic                  r_wr, r_rd;
    logic                  push, pop;

    assign push = div_tag.valid && en;
    assign pop  = (r_cnt != 2'd0) && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_level[r_wr]  <= n_level;
            r_q_region[r_wr] <= div_tag.region;
            r_q_fits[r_wr]   <= r_fits;
        end
    end

    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_pixel_level = r_q_level[r_rd];
    assign o_region      = r_q_region[r_rd];
    assign o_disc_fits   = r_q_fits[r_rd];

endmodule

@@ rtl/core/adpr_checker.sv @@
// adpr_checker: port-level assertions for antialiased_disc_pixel_render, with its bind.
// Depends on adpr_pkg; binds to the top level.
module adpr_checker import adpr_pkg::*; #(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [LEVEL_BITS-1:0] i_pixel_level,
    input logic [1:0]            i_region,
    input logic                  i_disc_fits
);

    // requests accepted but not yet delivered
    logic [7:0] r_outstanding;
    logic [7:0] n_outstanding;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_outstanding = r_outstanding + 8'(in_acc) - 8'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pixel_level)
            && $stable(i_region) && $stable(i_disc_fits))
        else $error("result changed or dropped while stalled");

    a_nofit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_disc_fits |-> i_pixel_level == '0)
        else $error("nonzero level with disc outside frame");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_outstanding != 8'd0)
        else $error("result with no outstanding request");

endmodule

bind antialiased_disc_pixel_render adpr_checker #(
    .LEVEL_BITS (LEVEL_BITS)
) u_adpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .i_in_ready    (o_in_ready),
    .i_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .i_pixel_level (o_pixel_level),
    .i_region      (o_region),
    .i_disc_fits   (o_disc_fits)
);
